// ===== hdl/lcdpm_pkg.sv =====
`timescale 1ns / 1ps

package lcdpm_pkg;

   localparam int ADDR_W     = 20;
   localparam int NIB_W      = 4;
   localparam int PITCH_W    = 12;
   localparam int LINE_W     = 6;
   localparam int BITOFF_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int OUT_COL_W  = 6;
   localparam int OUT_ROW_W  = 6;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int SHADOW_W   = 5;

   localparam logic [CSR_IDX_W-1:0] REG_DISPLAY_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_OFFSET   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MENU_START    = 3'd4;

   localparam logic [SHADOW_W-1:0] SHADOW_UNKNOWN  = 5'd16;
   localparam logic [LINE_W-1:0]   LINES_MAX       = 6'd63;
   localparam logic [ADDR_W-1:0]   BASE_EVEN_MASK  = 20'hffffe;
   localparam logic [BITOFF_W-1:0] BIT_OFFSET_WIDE = 3'd3;
   localparam logic [PITCH_W-1:0]  PITCH_EXTRA     = 12'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_BOUNDS,
      ST_LOOP,
      ST_ADDR,
      ST_READ,
      ST_CMP,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic div_start;
      logic div_step;
      logic set_target;
      logic loop_first;
      logic calc_addr;
      logic mem_read;
      logic cmp;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic below_base;
      logic pitch_zero;
      logic raw_oob;
      logic div_last;
      logic in_bounds;
      logic loop_more;
      logic changed;
      logic pend_valid;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== hdl/lcdpm_div.sv =====
`timescale 1ns / 1ps

module lcdpm_div
   import lcdpm_pkg::*;
(
   input  logic               clock,
   input  logic               start,
   input  logic               step,
   input  logic [ADDR_W-1:0]  dividend,
   input  logic [PITCH_W-1:0] divisor,
   output logic [ADDR_W-1:0]  quotient,
   output logic [PITCH_W-1:0] remainder,
   output logic               last
);

   localparam int CNT_W = $clog2(ADDR_W);

   logic [ADDR_W-1:0]  quo_ff;
   logic [PITCH_W-1:0] rem_ff;
   logic [PITCH_W-1:0] dvs_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [PITCH_W:0]   partial;
   logic [PITCH_W:0]   diff;
   logic               ge;
   logic [PITCH_W-1:0] rem_in;

   assign partial = {rem_ff, quo_ff[ADDR_W-1]};
   assign diff    = partial - {1'b0, dvs_ff};
   assign ge      = (partial >= {1'b0, dvs_ff});
   assign rem_in  = ge ? diff[PITCH_W-1:0] : partial[PITCH_W-1:0];

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
         cnt_ff <= '0;
      end else if (step) begin
         quo_ff <= {quo_ff[ADDR_W-2:0], ge};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign last      = (cnt_ff == CNT_W'(ADDR_W - 1));

endmodule

// ===== hdl/lcdpm_ctrl.sv =====
`timescale 1ns / 1ps

module lcdpm_ctrl
   import lcdpm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_base) begin
               state_in = ST_IDLE;
            end else if (status.pitch_zero) begin
               if (status.raw_oob) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.loop_first = 1'b1;
                  state_in = ST_LOOP;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            if (status.in_bounds) begin
               cmd.set_target = 1'b1;
               state_in = ST_ADDR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOP: begin
            state_in = status.loop_more ? ST_ADDR : ST_FLUSH;
         end
         ST_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!(status.changed && status.pend_valid && !status.out_free)) begin
               cmd.cmp = 1'b1;
               state_in = status.pitch_zero ? ST_LOOP : ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/lcdpm_dp.sv =====
`timescale 1ns / 1ps

module lcdpm_dp
   import lcdpm_pkg::*;
#(
   parameter int ROW_NIBBLES    = 34,
   parameter int SCREEN_ROWS    = 64,
   parameter int SHADOW_COLUMNS = 36
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_action,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [NIB_W-1:0]      req_nibble,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_COL_W-1:0]  rsp_column,
   output logic [OUT_ROW_W-1:0]  rsp_row,
   output logic [NIB_W-1:0]      rsp_pixels,
   output logic                  rsp_shifted,
   output logic                  rsp_last,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status
);

   localparam int DEPTH = SCREEN_ROWS * SHADOW_COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CLW   = $clog2(SHADOW_COLUMNS);
   localparam int RW    = $clog2(SCREEN_ROWS) + 1;
   localparam int CMPW  = (RW > LINE_W) ? RW : LINE_W;
   localparam int FULLW = ADDR_W + 1;

   logic [ADDR_W-1:0]   display_start_ff;
   logic [BITOFF_W-1:0] bit_offset_ff;
   logic [LINE_W-1:0]   last_line_ff;
   logic [PITCH_W-1:0]  pitch_pad_ff;
   logic [ADDR_W-1:0]   menu_base_ff;

   logic                action_ff;
   logic [ADDR_W-1:0]   address_ff;
   logic [NIB_W-1:0]    nibble_ff;

   logic [CLW-1:0]      col_ff;
   logic [RW-1:0]       row_ff;
   logic [AW-1:0]       idx_ff;
   logic [AW-1:0]       clr_ff;
   logic [SHADOW_W-1:0] rd_ff;
   logic [SHADOW_W-1:0] shadow_mem [DEPTH];

   logic                pend_valid_ff;
   logic [CLW-1:0]      pend_col_ff;
   logic [RW-1:0]       pend_row_ff;
   logic [NIB_W-1:0]    pend_pixels_ff;
   logic                pend_shifted_ff;

   logic                rsp_tvalid_ff;
   logic [OUT_COL_W-1:0] rsp_column_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [NIB_W-1:0]    rsp_pixels_ff;
   logic                rsp_shifted_ff;
   logic                rsp_last_ff;

   logic [LINE_W-1:0]   lines;
   logic [ADDR_W-1:0]   base;
   logic [ADDR_W-1:0]   offset;
   logic [PITCH_W-1:0]  pitch;
   logic [PITCH_W-1:0]  divisor;
   logic [ADDR_W-1:0]   quotient;
   logic [PITCH_W-1:0]  remainder;
   logic                div_last;
   logic [FULLW-1:0]    row_full;
   logic                changed;
   logic                shifted;
   logic                push;
   logic                out_free;

   assign lines   = (last_line_ff == '0) ? LINES_MAX : last_line_ff;
   assign base    = action_ff ? menu_base_ff : (display_start_ff & BASE_EVEN_MASK);
   assign offset  = address_ff - base;
   assign pitch   = PITCH_W'(ROW_NIBBLES) + pitch_pad_ff
                    + ((bit_offset_ff > BIT_OFFSET_WIDE) ? PITCH_EXTRA : '0);
   assign divisor = action_ff ? PITCH_W'(ROW_NIBBLES) : pitch;

   lcdpm_div u_div (
      .clock     (clock),
      .start     (cmd.div_start),
      .step      (cmd.div_step),
      .dividend  (offset),
      .divisor   (divisor),
      .quotient  (quotient),
      .remainder (remainder),
      .last      (div_last)
   );

   assign row_full = FULLW'(quotient)
                     + (action_ff ? (FULLW'(lines) + FULLW'(1)) : '0);
   assign changed  = (rd_ff != {1'b0, nibble_ff});
   assign shifted  = (CMPW'(row_ff) <= CMPW'(lines));
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign push     = (cmd.cmp && changed && pend_valid_ff) || cmd.flush;

   assign status.clear_done = (clr_ff == AW'(DEPTH - 1));
   assign status.below_base = (address_ff < base);
   assign status.pitch_zero = !action_ff && (pitch == '0);
   assign status.raw_oob    = (offset >= ADDR_W'(SHADOW_COLUMNS));
   assign status.div_last   = div_last;
   assign status.in_bounds  = (remainder < PITCH_W'(SHADOW_COLUMNS))
                              && (row_full < FULLW'(SCREEN_ROWS));
   assign status.loop_more  = (CMPW'(row_ff) < CMPW'(lines))
                              && (row_ff < RW'(SCREEN_ROWS));
   assign status.changed    = changed;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_start_ff <= '0;
         bit_offset_ff    <= '0;
         last_line_ff     <= '0;
         pitch_pad_ff     <= '0;
         menu_base_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_DISPLAY_START: display_start_ff <= csr_wdata[ADDR_W-1:0];
            REG_BIT_OFFSET:    bit_offset_ff    <= csr_wdata[BITOFF_W-1:0];
            REG_LINE_COUNT:    last_line_ff     <= csr_wdata[LINE_W-1:0];
            REG_LINE_OFFSET:   pitch_pad_ff     <= csr_wdata[PITCH_W-1:0];
            REG_MENU_START:    menu_base_ff     <= csr_wdata[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= req_action;
         address_ff <= req_address;
         nibble_ff  <= req_nibble;
      end
      if (cmd.set_target) begin
         col_ff <= CLW'(remainder);
         row_ff <= RW'(row_full);
      end else if (cmd.loop_first) begin
         col_ff <= CLW'(offset);
         row_ff <= '0;
      end else if (cmd.cmp) begin
         row_ff <= row_ff + 1'b1;
      end
      if (cmd.calc_addr) begin
         idx_ff <= AW'(row_ff) * AW'(SHADOW_COLUMNS) + AW'(col_ff);
      end
      if (cmd.mem_read) begin
         rd_ff <= shadow_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         shadow_mem[clr_ff] <= SHADOW_UNKNOWN;
      end else if (cmd.cmp && changed) begin
         shadow_mem[idx_ff] <= {1'b0, nibble_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !status.clear_done) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.cmp && changed) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp && changed) begin
         pend_col_ff     <= col_ff;
         pend_row_ff     <= row_ff;
         pend_pixels_ff  <= nibble_ff;
         pend_shifted_ff <= shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (push) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_column_ff  <= OUT_COL_W'(pend_col_ff);
         rsp_row_ff     <= OUT_ROW_W'(pend_row_ff);
         rsp_pixels_ff  <= pend_pixels_ff;
         rsp_shifted_ff <= pend_shifted_ff;
         rsp_last_ff    <= cmd.flush;
      end
   end

   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_column  = rsp_column_ff;
   assign rsp_row     = rsp_row_ff;
   assign rsp_pixels  = rsp_pixels_ff;
   assign rsp_shifted = rsp_shifted_ff;
   assign rsp_last    = rsp_last_ff;

   // A result is never written over one that has not yet been transferred.
   a_push_slot_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result register overwritten before transfer");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_valid_ff)
      else $error("pending item survived a flush");

   a_change_pends: assert property (@(posedge clock) disable iff (reset)
      (cmd.cmp && changed) |=> (pend_valid_ff && (pend_pixels_ff == $past(nibble_ff))))
      else $error("changed position not held as pending item");

   a_no_load_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !pend_valid_ff)
      else $error("new write accepted with an item still pending");

endmodule

// ===== hdl/lcd_write_to_pixel_mapper_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  tdata (lowest bit first)                tuser    tlast
// req_     in         address[19:0], nibble[23:20]            action   -
// rsp_     out        column[5:0], row[11:6], pixels[15:12],  -        last
//                     shifted[16], zero fill[23:17]
// csr_     in         csr_we, csr_index, csr_wdata (write only)
//
// After reset the shadow screen is cleared one entry a cycle, all
// SCREEN_ROWS * SHADOW_COLUMNS entries (2304 by default), before a write is accepted.
// A write that needs a division goes through the 20-step serial divider.
// A zero-pitch write runs loop, address, read and compare per row below the line count.
// A full result register stalls the block only when a further result must be passed on.

module lcd_write_to_pixel_mapper_top
   import lcdpm_pkg::*;
#(
   parameter int ROW_NIBBLES    = 34,
   parameter int SCREEN_ROWS    = 64,
   parameter int SHADOW_COLUMNS = 36
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // address, nibble
   input  logic                  req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // column, row, pixels, shifted
   output logic                  rsp_tlast
);

   ctrl_cmd_type         cmd;
   ctrl_status_type      status;
   logic [OUT_COL_W-1:0] rsp_column;
   logic [OUT_ROW_W-1:0] rsp_row;
   logic [NIB_W-1:0]     rsp_pixels;
   logic                 rsp_shifted;

   lcdpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcdpm_dp #(
      .ROW_NIBBLES    (ROW_NIBBLES),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .SHADOW_COLUMNS (SHADOW_COLUMNS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_action  (req_tuser),
      .req_address (req_tdata[ADDR_W-1:0]),
      .req_nibble  (req_tdata[ADDR_W+NIB_W-1:ADDR_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_column  (rsp_column),
      .rsp_row     (rsp_row),
      .rsp_pixels  (rsp_pixels),
      .rsp_shifted (rsp_shifted),
      .rsp_last    (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_shifted, rsp_pixels, rsp_row, rsp_column});

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import lcdpm_pkg::*;

   localparam int ROW_NIBBLES    = 34;
   localparam int SCREEN_ROWS    = 64;
   localparam int SHADOW_COLUMNS = 36;
   localparam int SETTLE_CYCLES  = 4 * SCREEN_ROWS + 64;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 57;

   class redraw_scoreboard;
      typedef struct packed {
         logic [OUT_COL_W-1:0] column;
         logic [OUT_ROW_W-1:0] row;
         logic [NIB_W-1:0]     pixels;
         logic                 shifted;
         logic                 last;
      } redraw_type;

      logic [SHADOW_W-1:0] shadow [SCREEN_ROWS*SHADOW_COLUMNS];
      logic [ADDR_W-1:0]   display_start;
      logic [BITOFF_W-1:0] bit_offset;
      logic [LINE_W-1:0]   last_line;
      logic [PITCH_W-1:0]  pitch_pad;
      logic [ADDR_W-1:0]   menu_base;
      redraw_type          pending_redraws [$];
      int                  errors;

      function new();
         display_start = '0;
         bit_offset    = '0;
         last_line     = '0;
         pitch_pad     = '0;
         menu_base     = '0;
         errors        = 0;
         foreach (shadow[i]) shadow[i] = SHADOW_UNKNOWN;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_DISPLAY_START: display_start = value[ADDR_W-1:0];
            REG_BIT_OFFSET:    bit_offset    = value[BITOFF_W-1:0];
            REG_LINE_COUNT:    last_line     = value[LINE_W-1:0];
            REG_LINE_OFFSET:   pitch_pad     = value[PITCH_W-1:0];
            REG_MENU_START:    menu_base     = value[ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned lines_eff();
         return 32'((last_line == '0) ? LINES_MAX : last_line);
      endfunction

      function int unsigned line_pitch();
         logic [PITCH_W-1:0] pitch;
         pitch = PITCH_W'(ROW_NIBBLES) + pitch_pad +
                 ((bit_offset > BIT_OFFSET_WIDE) ? PITCH_EXTRA : '0);
         return 32'(pitch);
      endfunction

      function int unsigned display_base();
         return 32'(display_start & BASE_EVEN_MASK);
      endfunction

      function void store_pixel(int unsigned col, int unsigned row, logic [NIB_W-1:0] nib);
         int unsigned idx;
         redraw_type item;
         idx = row * SHADOW_COLUMNS + col;
         if (shadow[idx] != {1'b0, nib}) begin
            shadow[idx]  = {1'b0, nib};
            item.column  = OUT_COL_W'(col);
            item.row     = OUT_ROW_W'(row);
            item.pixels  = nib;
            item.shifted = (row <= lines_eff());
            item.last    = 1'b0;
            pending_redraws.push_back(item);
         end
      endfunction

      function void map_write(logic action, logic [ADDR_W-1:0] addr, logic [NIB_W-1:0] nib);
         int unsigned lines, base, pitch, off, col, row, first;
         redraw_type item;
         first = pending_redraws.size();
         lines = lines_eff();
         if (!action) begin
            base  = display_base();
            pitch = line_pitch();
            if (addr >= base) begin
               off = addr - base;
               if (pitch == 0) begin
                  if (off < SHADOW_COLUMNS) begin
                     for (row = 0; row < lines && row < SCREEN_ROWS; row++) begin
                        store_pixel(off, row, nib);
                     end
                  end
               end else begin
                  col = off % pitch;
                  row = off / pitch;
                  if (col < SHADOW_COLUMNS && row < SCREEN_ROWS) store_pixel(col, row, nib);
               end
            end
         end else if (addr >= menu_base) begin
            off = addr - menu_base;
            col = off % ROW_NIBBLES;
            row = lines + 1 + off / ROW_NIBBLES;
            if (col < SHADOW_COLUMNS && row < SCREEN_ROWS) store_pixel(col, row, nib);
         end
         if (pending_redraws.size() > first) begin
            item = pending_redraws.pop_back();
            item.last = 1'b1;
            pending_redraws.push_back(item);
         end
      endfunction

      task report(string msg);
         errors++;
         $display("%0t: %s", $time, msg);
      endtask

      task check_redraw(logic [RSP_DATA_W-1:0] data, logic tlast);
         redraw_type item;
         if (pending_redraws.size() == 0) begin
            report($sformatf("unexpected redraw transfer: data %h last %b", data, tlast));
         end else begin
            item = pending_redraws.pop_front();
            if (data[5:0] != item.column)
               report($sformatf("column %0d, expected %0d", data[5:0], item.column));
            if (data[11:6] != item.row)
               report($sformatf("row %0d, expected %0d", data[11:6], item.row));
            if (data[15:12] != item.pixels)
               report($sformatf("pixels %h, expected %h", data[15:12], item.pixels));
            if (data[16] != item.shifted)
               report($sformatf("shifted %b, expected %b at row %0d", data[16], item.shifted,
                                item.row));
            if (tlast != item.last)
               report($sformatf("last %b, expected %b at row %0d", tlast, item.last, item.row));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_DISPLAY_START;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   logic                  idle_on = 1'b1;
   int                    stall_left = 0;
   logic                  prev_action = 1'b0;
   logic [ADDR_W-1:0]     prev_addr = '0;
   logic [NIB_W-1:0]      prev_nib = '0;
   redraw_scoreboard      sb;

   lcd_write_to_pixel_mapper_top #(
      .ROW_NIBBLES    (ROW_NIBBLES),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .SHADOW_COLUMNS (SHADOW_COLUMNS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         sb.check_redraw(rsp_tdata, rsp_tlast);
      end
      if (stall_left > 1) begin
         stall_left = stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 16);
         rsp_tready <= 1'b0;
      end
   end

   task automatic send_write(input logic action, input logic [ADDR_W-1:0] addr,
                             input logic [NIB_W-1:0] nib);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({nib, addr});
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      sb.map_write(action, addr, nib);
      prev_action = action;
      prev_addr   = addr;
      prev_nib    = nib;
   endtask

   task automatic send_random();
      logic              action;
      logic [ADDR_W-1:0] addr;
      logic [NIB_W-1:0]  nib;
      int unsigned       pitch, lines, pick;
      pitch  = sb.line_pitch();
      lines  = sb.lines_eff();
      pick   = $urandom_range(0, 99);
      action = 1'($urandom_range(0, 1));
      nib    = NIB_W'($urandom_range(0, 15));
      if (pick < 10) begin
         action = prev_action;
         addr   = prev_addr;
         if (pick < 5) nib = prev_nib;
      end else if (pick < 75) begin
         if (action) begin
            addr = ADDR_W'(sb.menu_base +
                           $urandom_range(0, ROW_NIBBLES * (SCREEN_ROWS - lines) + 8));
         end else if (pitch == 0) begin
            addr = ADDR_W'(sb.display_base() + $urandom_range(0, SHADOW_COLUMNS + 3));
         end else begin
            addr = ADDR_W'(sb.display_base() + $urandom_range(0, SCREEN_ROWS - 1) * pitch +
                           $urandom_range(0, SHADOW_COLUMNS - 1));
         end
      end else if (pick < 85) begin
         addr = ADDR_W'((action ? sb.menu_base : sb.display_base()) - $urandom_range(1, 3));
      end else begin
         addr = ADDR_W'($urandom());
      end
      send_write(action, addr, nib);
   endtask

   task automatic set_config(input logic [ADDR_W-1:0] ds, input logic [BITOFF_W-1:0] bo,
                             input logic [LINE_W-1:0] lc, input logic [PITCH_W-1:0] lo,
                             input logic [ADDR_W-1:0] ms);
      logic [CSR_IDX_W-1:0]  idxs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      int i;
      idxs = '{REG_DISPLAY_START, REG_BIT_OFFSET, REG_LINE_COUNT, REG_LINE_OFFSET,
               REG_MENU_START};
      vals = '{CSR_DATA_W'(ds), CSR_DATA_W'(bo), CSR_DATA_W'(lc), CSR_DATA_W'(lo),
               CSR_DATA_W'(ms)};
      for (i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(idxs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Stop sending, let every expected redraw arrive, then allow the slowest
   // write that produces nothing to finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_redraws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [BITOFF_W-1:0] bo;
      logic [LINE_W-1:0]   lc;
      logic [PITCH_W-1:0]  lo;
      logic [ADDR_W-1:0]   ds, ms;
      int p, i;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_write(1'b0, 20'd0, 4'h0);
      send_write(1'b0, 20'd0, 4'h0);
      send_write(1'b0, 20'd33, 4'hf);
      send_write(1'b0, 20'(34 * 63 + 33), 4'h9);
      send_write(1'b0, 20'(34 * 64), 4'h3);
      send_write(1'b1, 20'd0, 4'h6);
      send_write(1'b0, 20'hfffff, 4'h1);
      drain();

      set_config(20'h00101, 3'd4, 6'd10, 12'd0, 20'h00800);
      send_write(1'b0, 20'h000ff, 4'h2);
      send_write(1'b0, 20'(20'h100 + 35), 4'ha);
      send_write(1'b0, 20'(20'h100 + 36 * 10 + 5), 4'h5);
      send_write(1'b0, 20'(20'h100 + 36 * 11), 4'hc);
      send_write(1'b1, 20'h007ff, 4'h1);
      send_write(1'b1, 20'h00800, 4'h7);
      send_write(1'b1, 20'(20'h800 + 34 * 52 + 33), 4'he);
      send_write(1'b1, 20'(20'h800 + 34 * 53), 4'h4);
      drain();

      set_config(20'hfffff, 3'd7, 6'd3, 12'd4060, 20'hfffff);
      send_write(1'b0, 20'hffffe, 4'h5);
      send_write(1'b0, 20'hfffff, 4'ha);
      send_write(1'b0, 20'hffffd, 4'h3);
      send_write(1'b0, 20'hffffe, 4'h5);
      send_write(1'b1, 20'hfffff, 4'hb);
      drain();

      set_config(20'd0, 3'd0, 6'd0, 12'd4062, 20'd0);
      send_write(1'b0, 20'd36, 4'h1);
      send_write(1'b0, 20'd35, 4'ha);
      send_write(1'b0, 20'd35, 4'ha);
      drain();

      set_config(20'd0, 3'd3, 6'd63, 12'd4095, 20'd0);
      send_write(1'b0, 20'(33 * 5 + 32), 4'h8);
      send_write(1'b1, 20'd0, 4'h3);

      for (p = 0; p < PHASES; p++) begin
         drain();
         bo = BITOFF_W'($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: lc = 6'd0;
            1: lc = 6'd63;
            default: lc = LINE_W'($urandom_range(1, 62));
         endcase
         ds = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 20'hfffff))
                                   : ADDR_W'($urandom_range(0, 255));
         ms = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 20'hfffff))
                                   : ADDR_W'($urandom_range(0, 255));
         if (p == 1 || p == 4) begin
            // Zero line pitch: every row below the line count takes the write.
            lo = (bo > BIT_OFFSET_WIDE) ? 12'd4060 : 12'd4062;
            lc = (p == 1) ? 6'($urandom_range(1, 8)) : 6'd0;
         end else if (p == 6) begin
            lo = 12'd4095;
         end else begin
            case ($urandom_range(0, 3))
               0: lo = 12'd0;
               1: lo = PITCH_W'($urandom_range(0, 4095));
               default: lo = PITCH_W'($urandom_range(0, 26));
            endcase
         end
         set_config(ds, bo, lc, lo, ms);
         if (p == PHASES - 1) idle_on <= 1'b0;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p != PHASES - 1 && i % 25 == 0) idle_on <= ($urandom_range(0, 3) != 0);
            send_random();
         end
      end
      drain();

      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== lcd_write_to_pixel_mapper_top.f =====
hdl/lcdpm_pkg.sv
hdl/lcdpm_div.sv
hdl/lcdpm_ctrl.sv
hdl/lcdpm_dp.sv
hdl/lcd_write_to_pixel_mapper_top.sv
dv/testbench.sv
